/* hdl/tcw_pkg.sv */
// Package for the text console character writer.
// Shared widths, operation and character codes, and controller/datapath structs.
// No dependencies.
`timescale 1ns / 1ps

package tcw_pkg;

	localparam int COLUMNS_DEFAULT = 80;
	localparam int ROWS_DEFAULT    = 25;

	localparam int COL_W  = 7;
	localparam int ROW_W  = 5;
	localparam int ADDR_W = 11;
	localparam int BYTE_W = 8;
	localparam int OP_W   = 2;

	localparam logic [OP_W-1:0] OP_PUT      = 2'd0;
	localparam logic [OP_W-1:0] OP_SET_STOP = 2'd1;
	localparam logic [OP_W-1:0] OP_CLR_STOP = 2'd2;
	localparam logic [OP_W-1:0] OP_READ     = 2'd3;

	localparam logic [BYTE_W-1:0] CH_BS    = 8'h08;
	localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
	localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
	localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
	localparam logic [BYTE_W-1:0] CH_BLANK = 8'h20;

	localparam logic [BYTE_W-1:0] ATTR_RESET = 8'h9F;

	typedef struct packed {
		logic start;
		logic clear_step;
		logic copy_step;
		logic load_out;
	} tcw_cmd_t;

	typedef struct packed {
		logic acc_scroll;
		logic clear_last;
		logic copy_last;
	} tcw_sts_t;

endpackage

/* hdl/text_console_char_writer.sv */
// Top level of the text console character writer.
// Joins tcw_ctrl and tcw_datapath; depends on tcw_pkg.
`timescale 1ns / 1ps

// Usage:
//   Input channel (in_valid/in_stall) takes one op with char_byte and
//   read_address per transaction. Output channel (out_valid/out_stall) returns
//   one result per input transaction: cursor after the op, write and scroll
//   flags, and the cell read by a read op.
//   The cfg channel (cfg_valid/cfg_ready, ready always high) loads the
//   attribute stored with every written cell; write it only while idle.
// Sequence:
//   Put without scroll, stop point ops and reads: the accept cycle, then
//   the load of the output register, which waits while out_stall holds a result.
//   A put that scrolls first runs the copy sweep, which moves rows up through
//   the single write port of the cell memory.
// Reset:
//   After arst_n releases, a clearing pass zeroes the whole cell memory
//   with in_stall high.
// Stall:
//   A result held by out_stall keeps its payload; the block finishes at most
//   one further item and then holds it, with in_stall high, until taken.

module text_console_char_writer #(
	parameter int COLUMNS = tcw_pkg::COLUMNS_DEFAULT,
	parameter int ROWS    = tcw_pkg::ROWS_DEFAULT
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [tcw_pkg::BYTE_W-1:0]  text_attribute,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [tcw_pkg::OP_W-1:0]    op,
	input  logic [tcw_pkg::BYTE_W-1:0]  char_byte,
	input  logic [tcw_pkg::ADDR_W-1:0]  read_address,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [tcw_pkg::COL_W-1:0]   cursor_column,
	output logic [tcw_pkg::ROW_W-1:0]   cursor_row,
	output logic [tcw_pkg::ADDR_W-1:0]  cursor_location,
	output logic                        cell_written,
	output logic [tcw_pkg::ADDR_W-1:0]  write_address,
	output logic                        scrolled,
	output logic [tcw_pkg::BYTE_W-1:0]  read_char,
	output logic [tcw_pkg::BYTE_W-1:0]  read_attribute
);

	localparam int HOME_ROW = ROWS - 2;

	tcw_pkg::tcw_cmd_t cmd;
	tcw_pkg::tcw_sts_t sts;

	assign cfg_ready = 1'b1;

	tcw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	tcw_datapath #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.attr_we         (cfg_valid),
		.attr_wd         (text_attribute),
		.op              (op),
		.char_byte       (char_byte),
		.read_address    (read_address),
		.cursor_column   (cursor_column),
		.cursor_row      (cursor_row),
		.cursor_location (cursor_location),
		.cell_written    (cell_written),
		.write_address   (write_address),
		.scrolled        (scrolled),
		.read_char       (read_char),
		.read_attribute  (read_attribute)
	);

	a_one_item_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input accepted while an item is in flight");

	a_cursor_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> (cursor_column < COLUMNS) && (cursor_row < ROWS - 1))
		else $error("result cursor outside the text area");

	a_scroll_homes_cursor: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !scrolled || (cursor_row == HOME_ROW && cursor_column == '0))
		else $error("scroll did not home the cursor");

	a_copy_excludes_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.copy_step |-> !cmd.load_out && !cmd.start && in_stall)
		else $error("scroll copy overlaps item start or result load");

endmodule

/* hdl/tcw_ctrl.sv */
// Controller state machine for the text console character writer.
// Sequences clearing, item execution, scroll copy and result hand-off.
// Depends on tcw_pkg.
`timescale 1ns / 1ps

module tcw_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	output logic               out_valid,
	input  logic               out_stall,
	input  tcw_pkg::tcw_sts_t  sts,
	output tcw_pkg::tcw_cmd_t  cmd
);

	localparam logic [1:0] S_CLEAR = 2'd0;
	localparam logic [1:0] S_IDLE  = 2'd1;
	localparam logic [1:0] S_COPY  = 2'd2;
	localparam logic [1:0] S_DONE  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_n;
	logic       out_valid_q;

	always_comb begin
		cmd     = '0;
		state_n = state_q;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clear_step = 1'b1;
				if (sts.clear_last) begin
					state_n = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.start = 1'b1;
					state_n   = sts.acc_scroll ? S_COPY : S_DONE;
				end
			end
			S_COPY: begin
				cmd.copy_step = 1'b1;
				if (sts.copy_last) begin
					state_n = S_DONE;
				end
			end
			S_DONE: begin
				if (!out_valid_q || !out_stall) begin
					cmd.load_out = 1'b1;
					state_n      = S_IDLE;
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

endmodule

/* hdl/tcw_datapath.sv */
// Datapath for the text console character writer: cursor and stop point
// registers, attribute register, screen cell memory, sweep counter, result registers.
// Depends on tcw_pkg.
`timescale 1ns / 1ps

module tcw_datapath #(
	parameter int COLUMNS = tcw_pkg::COLUMNS_DEFAULT,
	parameter int ROWS    = tcw_pkg::ROWS_DEFAULT
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  tcw_pkg::tcw_cmd_t           cmd,
	output tcw_pkg::tcw_sts_t           sts,
	input  logic                        attr_we,
	input  logic [tcw_pkg::BYTE_W-1:0]  attr_wd,
	input  logic [tcw_pkg::OP_W-1:0]    op,
	input  logic [tcw_pkg::BYTE_W-1:0]  char_byte,
	input  logic [tcw_pkg::ADDR_W-1:0]  read_address,
	output logic [tcw_pkg::COL_W-1:0]   cursor_column,
	output logic [tcw_pkg::ROW_W-1:0]   cursor_row,
	output logic [tcw_pkg::ADDR_W-1:0]  cursor_location,
	output logic                        cell_written,
	output logic [tcw_pkg::ADDR_W-1:0]  write_address,
	output logic                        scrolled,
	output logic [tcw_pkg::BYTE_W-1:0]  read_char,
	output logic [tcw_pkg::BYTE_W-1:0]  read_attribute
);

	localparam int COL_W  = tcw_pkg::COL_W;
	localparam int ROW_W  = tcw_pkg::ROW_W;
	localparam int ADDR_W = tcw_pkg::ADDR_W;
	localparam int BYTE_W = tcw_pkg::BYTE_W;
	localparam int CELLS  = COLUMNS * ROWS;
	localparam int IDX_W  = $clog2(CELLS);
	localparam int LOC_W  = ROW_W + 8;
	localparam int XW     = COL_W + 1;
	localparam int CELL_W = 2 * BYTE_W;

	localparam logic [LOC_W-1:0] COL_LOC   = LOC_W'(COLUMNS);
	localparam logic [LOC_W-1:0] CELLS_LOC = LOC_W'(CELLS);
	localparam logic [IDX_W-1:0] COL_IDX   = IDX_W'(COLUMNS);
	localparam logic [IDX_W-1:0] CLEAR_END = IDX_W'(CELLS - 1);
	localparam logic [IDX_W-1:0] COPY_END  = IDX_W'((ROWS - 1) * COLUMNS - 1);
	localparam logic [XW-1:0]    X_LIMIT   = XW'(COLUMNS);
	localparam logic [XW-1:0]    X_LAST    = XW'(COLUMNS - 1);
	localparam logic [ROW_W-1:0] Y_SCROLL  = ROW_W'(ROWS - 1);
	localparam logic [ROW_W-1:0] Y_HOME    = ROW_W'(ROWS - 2);

	logic [CELL_W-1:0] mem [CELLS];

	logic [COL_W-1:0]  cursor_x_q;
	logic [ROW_W-1:0]  cursor_y_q;
	logic              stop_valid_q;
	logic [COL_W-1:0]  stop_x_q;
	logic [ROW_W-1:0]  stop_y_q;
	logic [BYTE_W-1:0] attr_q;
	logic [IDX_W-1:0]  cnt_q;
	logic              cv_s1;
	logic [IDX_W-1:0]  wa_s1;
	logic [CELL_W-1:0] rd_q;

	logic              written_q;
	logic [ADDR_W-1:0] waddr_q;
	logic              scrolled_q;
	logic              read_hit_q;

	logic [COL_W-1:0]  res_col_q;
	logic [ROW_W-1:0]  res_row_q;
	logic [ADDR_W-1:0] res_loc_q;
	logic              res_written_q;
	logic [ADDR_W-1:0] res_waddr_q;
	logic              res_scrolled_q;
	logic [BYTE_W-1:0] res_char_q;
	logic [BYTE_W-1:0] res_attr_q;

	logic              is_put;
	logic              is_read;
	logic              blocked;
	logic              put_wr;
	logic              scroll_n;
	logic [BYTE_W-1:0] put_char;
	logic [XW-1:0]     x_n;
	logic [ROW_W-1:0]  y_n;
	logic [XW-1:0]     tab_sum;
	logic [COL_W-1:0]  wr_x;
	logic [ROW_W-1:0]  wr_y;
	logic [LOC_W-1:0]  wr_idx;
	logic [LOC_W-1:0]  loc_full;
	logic [LOC_W-1:0]  ra_ext;

	logic              mem_we;
	logic [IDX_W-1:0]  mem_wa;
	logic [CELL_W-1:0] mem_wd;
	logic              mem_re;
	logic [IDX_W-1:0]  mem_ra;

	assign is_put  = (op == tcw_pkg::OP_PUT);
	assign is_read = (op == tcw_pkg::OP_READ);
	assign tab_sum = {1'b0, cursor_x_q} + XW'(8);
	assign ra_ext  = LOC_W'(read_address);

	// next cursor for a put
	always_comb begin
		x_n      = {1'b0, cursor_x_q};
		y_n      = cursor_y_q;
		wr_x     = cursor_x_q;
		wr_y     = cursor_y_q;
		blocked  = 1'b0;
		put_wr   = 1'b0;
		scroll_n = 1'b0;
		put_char = char_byte;
		if (char_byte == tcw_pkg::CH_BS) begin
			if (stop_valid_q && cursor_x_q == stop_x_q && cursor_y_q == stop_y_q) begin
				blocked = 1'b1;
			end else begin
				if (cursor_x_q == '0) begin
					x_n = X_LAST;
					if (cursor_y_q != '0) begin
						y_n = cursor_y_q - ROW_W'(1);
					end
				end else begin
					x_n = {1'b0, cursor_x_q} - XW'(1);
				end
				wr_x     = x_n[COL_W-1:0];
				wr_y     = y_n;
				put_wr   = 1'b1;
				put_char = tcw_pkg::CH_BLANK;
			end
		end else if (char_byte == tcw_pkg::CH_TAB) begin
			x_n = {tab_sum[XW-1:3], 3'b000};
		end else if (char_byte == tcw_pkg::CH_CR) begin
			x_n = '0;
		end else if (char_byte == tcw_pkg::CH_LF) begin
			x_n = '0;
			y_n = cursor_y_q + ROW_W'(1);
		end else if (char_byte >= tcw_pkg::CH_BLANK) begin
			put_wr = 1'b1;
			x_n    = {1'b0, cursor_x_q} + XW'(1);
		end
		if (!blocked) begin
			if (x_n >= X_LIMIT) begin
				x_n = '0;
				y_n = y_n + ROW_W'(1);
			end
			if (y_n >= Y_SCROLL) begin
				scroll_n = 1'b1;
				y_n      = Y_HOME;
				x_n      = '0;
			end
		end
	end

	assign wr_idx   = LOC_W'(wr_y) * COL_LOC + LOC_W'(wr_x);
	assign loc_full = LOC_W'(cursor_y_q) * COL_LOC + LOC_W'(cursor_x_q);

	assign sts.acc_scroll = is_put && scroll_n;
	assign sts.clear_last = (cnt_q == CLEAR_END);
	assign sts.copy_last  = (cnt_q == COPY_END);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_x_q   <= '0;
			cursor_y_q   <= ROW_W'(1);
			stop_valid_q <= 1'b1;
			stop_x_q     <= '0;
			stop_y_q     <= '0;
			attr_q       <= tcw_pkg::ATTR_RESET;
			cnt_q        <= '0;
			cv_s1        <= 1'b0;
		end else begin
			if (attr_we) begin
				attr_q <= attr_wd;
			end
			cv_s1 <= cmd.copy_step;
			if (cmd.start) begin
				cnt_q <= COL_IDX;
				unique case (op)
					tcw_pkg::OP_PUT: begin
						cursor_x_q <= x_n[COL_W-1:0];
						cursor_y_q <= y_n;
					end
					tcw_pkg::OP_SET_STOP: begin
						stop_valid_q <= 1'b1;
						stop_x_q     <= cursor_x_q;
						stop_y_q     <= cursor_y_q;
					end
					tcw_pkg::OP_CLR_STOP: begin
						stop_valid_q <= 1'b0;
					end
					tcw_pkg::OP_READ: begin
					end
				endcase
			end else if (cmd.clear_step || cmd.copy_step) begin
				cnt_q <= cnt_q + IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		wa_s1 <= cnt_q;
		if (cmd.start) begin
			written_q  <= is_put && put_wr;
			waddr_q    <= (is_put && put_wr) ? wr_idx[ADDR_W-1:0] : '0;
			scrolled_q <= is_put && scroll_n;
			read_hit_q <= is_read && (ra_ext < CELLS_LOC);
		end
		if (cmd.load_out) begin
			res_col_q      <= cursor_x_q;
			res_row_q      <= cursor_y_q;
			res_loc_q      <= loc_full[ADDR_W-1:0];
			res_written_q  <= written_q;
			res_waddr_q    <= waddr_q;
			res_scrolled_q <= scrolled_q;
			res_char_q     <= read_hit_q ? rd_q[BYTE_W-1:0] : '0;
			res_attr_q     <= read_hit_q ? rd_q[CELL_W-1:BYTE_W] : '0;
		end
	end

	// one write port: copy write, clearing pass, or put
	assign mem_we = cv_s1 || cmd.clear_step || (cmd.start && is_put && put_wr);
	assign mem_wa = cv_s1 ? wa_s1 : (cmd.clear_step ? cnt_q : wr_idx[IDX_W-1:0]);
	assign mem_wd = cv_s1 ? rd_q : (cmd.clear_step ? '0 : {attr_q, put_char});
	assign mem_re = cmd.copy_step || (cmd.start && is_read);
	assign mem_ra = cmd.copy_step ? (cnt_q + COL_IDX) : ra_ext[IDX_W-1:0];

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rd_q <= mem[mem_ra];
		end
	end

	assign cursor_column   = res_col_q;
	assign cursor_row      = res_row_q;
	assign cursor_location = res_loc_q;
	assign cell_written    = res_written_q;
	assign write_address   = res_waddr_q;
	assign scrolled        = res_scrolled_q;
	assign read_char       = res_char_q;
	assign read_attribute  = res_attr_q;

endmodule
